### hdl/bcc_pkg.sv
// Shared types, constants and helper functions for the button click/hold classifier.
`timescale 1ns / 1ps

package bcc_pkg;

  localparam int unsigned CntW     = 16;
  localparam int unsigned SetupW   = 22;
  localparam int unsigned CfgDataW = 22;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] RegDebounce        = 2'd0;
  localparam logic [CfgAddrW-1:0] RegHold            = 2'd1;
  localparam logic [CfgAddrW-1:0] RegReleaseDebounce = 2'd2;
  localparam logic [CfgAddrW-1:0] RegSetupTimeout    = 2'd3;

  localparam logic [CntW-1:0]   DebounceRst        = 16'd50;
  localparam logic [CntW-1:0]   HoldRst            = 16'd5000;
  localparam logic [CntW-1:0]   ReleaseDebounceRst = 16'd200;
  localparam logic [SetupW-1:0] SetupTimeoutRst    = 22'd300000;

  typedef struct packed {
    logic [CntW-1:0]   debounce_ms;
    logic [CntW-1:0]   hold_ms;
    logic [CntW-1:0]   release_debounce_ms;
    logic [SetupW-1:0] setup_timeout_ms;
  } bcc_cfg_t;

  typedef struct packed {
    logic              key_down;
    logic [CntW-1:0]   hold_count;
    logic              settling;
    logic [CntW-1:0]   settle_count;
    logic              in_setup;
    logic [SetupW-1:0] setup_count;
    logic              released_in_setup;
    logic [CntW-1:0]   release_count;
    logic              last_level;
  } bcc_state_t;

  typedef struct packed {
    logic setup_active;
    logic restart_request;
    logic setup_entered;
    logic toggle_request;
  } bcc_result_t;

  function automatic logic [CntW-1:0] sat_inc16(input logic [CntW-1:0] v);
    sat_inc16 = (v == {CntW{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic logic [SetupW-1:0] sat_inc22(input logic [SetupW-1:0] v);
    sat_inc22 = (v == {SetupW{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

### hdl/bcc_cfg.sv
// Configuration register file for the button click/hold classifier.
`timescale 1ns / 1ps

module bcc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [bcc_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [bcc_pkg::CfgDataW-1:0]   cfg_wdata,
  output bcc_pkg::bcc_cfg_t              cfg
);

  bcc_pkg::bcc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ms         <= bcc_pkg::DebounceRst;
      cfg_r.hold_ms             <= bcc_pkg::HoldRst;
      cfg_r.release_debounce_ms <= bcc_pkg::ReleaseDebounceRst;
      cfg_r.setup_timeout_ms    <= bcc_pkg::SetupTimeoutRst;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        bcc_pkg::RegDebounce:
          cfg_r.debounce_ms <= cfg_wdata[bcc_pkg::CntW-1:0];
        bcc_pkg::RegHold:
          cfg_r.hold_ms <= cfg_wdata[bcc_pkg::CntW-1:0];
        bcc_pkg::RegReleaseDebounce:
          cfg_r.release_debounce_ms <= cfg_wdata[bcc_pkg::CntW-1:0];
        bcc_pkg::RegSetupTimeout:
          cfg_r.setup_timeout_ms <= cfg_wdata[bcc_pkg::SetupW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### hdl/bcc_step.sv
// Per-tick next-state and result logic of the button click/hold classifier.
`timescale 1ns / 1ps

module bcc_step (
  input  bcc_pkg::bcc_cfg_t    cfg,
  input  bcc_pkg::bcc_state_t  st,
  input  logic                 pressed,
  output bcc_pkg::bcc_state_t  st_nxt,
  output bcc_pkg::bcc_result_t res
);

  always_comb begin
    bcc_pkg::bcc_state_t s;
    logic tog;
    logic ent;
    logic rst;
    s   = st;
    tog = 1'b0;
    ent = 1'b0;
    rst = 1'b0;

    if (st.in_setup) begin
      s.setup_count = bcc_pkg::sat_inc22(st.setup_count);
      if (s.setup_count > cfg.setup_timeout_ms) begin
        rst = 1'b1;
      end else begin
        if (st.released_in_setup) begin
          s.release_count = bcc_pkg::sat_inc16(st.release_count);
        end
        // The first release in setup mode starts the re-press debounce window.
        if (!pressed && st.last_level && !st.released_in_setup) begin
          s.released_in_setup = 1'b1;
          s.release_count     = '0;
        end
        if (pressed && !st.last_level && s.released_in_setup &&
            (s.release_count >= cfg.release_debounce_ms)) begin
          rst = 1'b1;
        end
        s.last_level = pressed;
      end
      if (rst) begin
        s = '0;
      end
    end else if (st.settling) begin
      // The button level is ignored on every settling tick.
      s.settle_count = bcc_pkg::sat_inc16(st.settle_count);
      if (s.settle_count >= cfg.debounce_ms) begin
        s.settling = 1'b0;
      end
    end else begin
      if (st.key_down) begin
        s.hold_count = bcc_pkg::sat_inc16(st.hold_count);
      end
      if (pressed && !st.key_down) begin
        s.key_down   = 1'b1;
        s.hold_count = '0;
      end
      if (pressed && s.key_down && (s.hold_count >= cfg.hold_ms)) begin
        ent                 = 1'b1;
        s.in_setup          = 1'b1;
        s.setup_count       = '0;
        s.released_in_setup = 1'b0;
        s.release_count     = '0;
        s.last_level        = 1'b1;
        s.key_down          = 1'b0;
        s.hold_count        = '0;
      end else if (!pressed && s.key_down) begin
        tog            = (s.hold_count < cfg.hold_ms);
        s.key_down     = 1'b0;
        s.settling     = 1'b1;
        s.settle_count = '0;
      end
    end

    st_nxt              = s;
    res.toggle_request  = tog;
    res.setup_entered   = ent;
    res.restart_request = rst;
    res.setup_active    = s.in_setup;
  end

endmodule

### hdl/button_click_hold_classifier.sv
// Top level of the button click/hold classifier: state, output register and handshakes.
// Usage:
// Each transfer on the in_ stream is one millisecond tick carrying the sampled
// button level in in_tdata bit 0. Every input transfer produces exactly one
// result transfer on the out_ stream with four flags: toggle_request,
// setup_entered, restart_request and setup_active.
// The result of a tick is registered: it appears on out_tvalid in the cycle
// after its input transfer. Throughput is one tick per cycle while the receiver
// keeps up, set by the single state register bank updated on every accepted transfer.
// A single output register holds the result; in_tready is high when that
// register is empty or is being emptied, so a stalled receiver holds off the
// input only while a result waits.
// Timing thresholds are written through cfg_wr_en/cfg_addr/cfg_wdata while the
// stream is idle. Index 0 is debounce_ms, 1 hold_ms, 2 release_debounce_ms and
// 3 setup_timeout_ms.
// Synchronous reset (rst_n low) clears all classifier state, empties the output
// register and loads the default thresholds 50, 5000, 200 and 300000 ticks.
`timescale 1ns / 1ps

module button_click_hold_classifier (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [0] pressed, [7:1] zero
  input  logic [bcc_pkg::InDataW-1:0]     in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] toggle_request, [1] setup_entered, [2] restart_request, [3] setup_active, [7:4] zero
  output logic [bcc_pkg::OutDataW-1:0]    out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [bcc_pkg::CfgAddrW-1:0]    cfg_addr,
  input  logic [bcc_pkg::CfgDataW-1:0]    cfg_wdata
);

  bcc_pkg::bcc_cfg_t    cfg;
  bcc_pkg::bcc_state_t  state_r;
  bcc_pkg::bcc_state_t  state_nxt;
  bcc_pkg::bcc_result_t res;
  bcc_pkg::bcc_result_t res_r;
  logic                 out_valid_r;
  logic                 in_xfer;

  bcc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bcc_step u_step (
    .cfg     (cfg),
    .st      (state_r),
    .pressed (in_tdata[0]),
    .st_nxt  (state_nxt),
    .res     (res)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bcc_pkg::OutDataW - 4){1'b0}}, res_r};

  // A short click and a setup entry are exclusive outcomes of one tick.
  a_tog_ent_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.toggle_request && res_r.setup_entered))
    else $error("toggle and setup entry reported on the same tick");

  a_ent_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.setup_entered) |-> res_r.setup_active)
    else $error("setup entry without setup mode");

  a_rst_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.restart_request) |-> (!res_r.setup_active && !state_r.in_setup))
    else $error("restart left the block in setup mode");

  a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(state_r.settling && state_r.in_setup))
    else $error("settling and setup mode active together");

  a_xfer_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (out_valid_r && (res_r.setup_active == state_r.in_setup)))
    else $error("accepted tick did not produce a consistent result");

endmodule
